// ===== rtl/krt_pkg.sv =====
// Shared types and codes for the keyed record table.
package krt_pkg;

  localparam int MAX_LIST = 16;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_READ = 2'd2,
    OP_LIST = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] grade_c;
    logic [7:0] course_c;
    logic [7:0] grade_b;
    logic [7:0] course_b;
    logic [7:0] grade_a;
    logic [7:0] course_a;
    logic [7:0] year;
    logic [7:0] key;
  } rec_t;

  typedef struct packed {
    logic re;
    logic we;
  } krt_mem_ctl_t;

endpackage

// ===== rtl/krt_mem.sv =====
// Record store: one write port, one read port, registered read data.
module krt_mem import krt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic         clk,
  input  krt_mem_ctl_t ctl,
  input  logic [AW-1:0] waddr,
  input  rec_t         wdata,
  input  logic [AW-1:0] raddr,
  output rec_t         rdata
);

  rec_t mem [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/keyed_record_table_top.sv =====
// Keyed record table: sequencer, count and result register around the record store.
//
// Input words (in_valid/in_stall) carry an opcode, a key and the record bytes.
// Result words (out_valid/out_stall) carry status, the found or listed key, the
// record bytes on a read hit, the used count, the full flag and last.
// One input word is taken at a time; in_stall stays high until its last result
// has been loaded into the output register.
// Add, and any request on an empty table: S_DISP sets the result, then S_RESP loads it.
// Read and delete: the search walks the store one slot per cycle through the
// single read port; a delete then moves each later record down one slot per
// cycle (read one slot, write the one below).
// List: from slot 0, one key per cycle while out_stall is low, at most 16 keys.
// The output register holds a result while out_stall is high; the sequencer
// waits on it and the held store read data stays put.
// Reset empties the table (count to zero); store contents are not cleared and
// no slot at or above the count is ever read.
module keyed_record_table_top import krt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_key,
  input  logic [7:0] in_year_in,
  input  logic [7:0] in_course_a_in,
  input  logic [7:0] in_grade_a_in,
  input  logic [7:0] in_course_b_in,
  input  logic [7:0] in_grade_b_in,
  input  logic [7:0] in_course_c_in,
  input  logic [7:0] in_grade_c_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_key_out,
  output logic [7:0] out_year_out,
  output logic [7:0] out_course_a_out,
  output logic [7:0] out_grade_a_out,
  output logic [7:0] out_course_b_out,
  output logic [7:0] out_grade_b_out,
  output logic [7:0] out_course_c_out,
  output logic [7:0] out_grade_c_out,
  output logic [4:0] out_used_count,
  output logic       out_is_full,
  output logic       out_last
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  op_t              op_r, op_nxt;
  logic [7:0]       key_r, key_nxt;
  rec_t             req_r, req_nxt;
  status_t          res_status_r, res_status_nxt;
  rec_t             res_rec_r, res_rec_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic [4:0]       out_cnt_r, out_cnt_nxt;
  logic             out_full_r, out_full_nxt;
  logic             out_last_r, out_last_nxt;

  krt_mem_ctl_t     mem_ctl;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  rec_t             mem_wdata, mem_rdata;

  logic             in_acc, out_free, load;
  logic             at_end, shift_end, list_last;
  rec_t             in_rec;

  krt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign at_end    = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign shift_end = (CNT_W'(idx_r) + CNT_W'(2)) == count_r;
  assign list_last = at_end || (32'(idx_r) == MAX_LIST - 1);

  always_comb begin
    in_rec.key      = in_key;
    in_rec.year     = in_year_in;
    in_rec.course_a = in_course_a_in;
    in_rec.grade_a  = in_grade_a_in;
    in_rec.course_b = in_course_b_in;
    in_rec.grade_b  = in_grade_b_in;
    in_rec.course_c = in_course_c_in;
    in_rec.grade_c  = in_grade_c_in;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_cnt_nxt    = out_cnt_r;
    out_full_nxt   = out_full_r;
    out_last_nxt   = out_last_r;
    mem_ctl        = '0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = idx_r + AW'(1);
    load           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = op_t'(in_opcode);
          key_nxt   = in_key;
          req_nxt   = in_rec;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_rec_nxt = '0;
        idx_nxt     = '0;
        if (op_r == OP_ADD) begin
          if (count_r == CNT_W'(DEPTH)) begin
            res_status_nxt = ST_FULL;
          end else begin
            mem_ctl.we     = 1'b1;
            mem_waddr      = AW'(count_r);
            mem_wdata      = req_r;
            count_nxt      = count_r + CNT_W'(1);
            res_status_nxt = ST_OK;
          end
          state_nxt = S_RESP;
        end else if (count_r == '0) begin
          res_status_nxt = ST_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = '0;
          state_nxt  = (op_r == OP_LIST) ? S_LIST : S_SCAN;
        end
      end
      S_SCAN: begin
        if (mem_rdata.key == key_r) begin
          res_status_nxt = ST_OK;
          if (op_r == OP_READ) begin
            res_rec_nxt = mem_rdata;
            state_nxt   = S_RESP;
          end else if (at_end) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESP;
          end else begin
            mem_ctl.re = 1'b1;
            state_nxt  = S_SHIFT;
          end
        end else if (at_end) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_RESP;
        end else begin
          mem_ctl.re = 1'b1;
          idx_nxt    = idx_r + AW'(1);
        end
      end
      S_SHIFT: begin
        mem_ctl.we = 1'b1;
        idx_nxt    = idx_r + AW'(1);
        if (shift_end) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = AW'(CNT_W'(idx_r) + CNT_W'(2));
        end
      end
      S_LIST: begin
        if (out_free) begin
          load           = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_rec_nxt    = '0;
          out_rec_nxt.key = mem_rdata.key;
          out_cnt_nxt    = 5'(count_r);
          out_full_nxt   = (count_r == CNT_W'(DEPTH));
          out_last_nxt   = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_ctl.re = 1'b1;
            idx_nxt    = idx_r + AW'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          load           = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rec_nxt    = res_rec_r;
          out_cnt_nxt    = 5'(count_r);
          out_full_nxt   = (count_r == CNT_W'(DEPTH));
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_full_r   <= out_full_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_key_out      = out_rec_r.key;
  assign out_year_out     = out_rec_r.year;
  assign out_course_a_out = out_rec_r.course_a;
  assign out_grade_a_out  = out_rec_r.grade_a;
  assign out_course_b_out = out_rec_r.course_b;
  assign out_grade_b_out  = out_rec_r.grade_b;
  assign out_course_c_out = out_rec_r.course_c;
  assign out_grade_c_out  = out_rec_r.grade_c;
  assign out_used_count   = out_cnt_r;
  assign out_is_full      = out_full_r;
  assign out_last         = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("record count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DISP && state_r != S_SCAN && state_r != S_SHIFT) |=>
      (count_r == $past(count_r)))
    else $error("record count moved outside an operation");

  a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |-> (CNT_W'(mem_waddr) <= count_r))
    else $error("store write beyond packed region");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a held word");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyed_record_table_top: directed request table, then random words.
module tb;
  import krt_pkg::*;

  localparam int DEPTH = 16;
  localparam int TAIL_CYCLES = 3 * DEPTH + 8;
  localparam int RANDOM_WORDS = 280;

  typedef struct packed {
    status_t    status;
    rec_t       data;
    logic [4:0] used;
    logic       full;
    logic       last;
  } reply_t;

  typedef struct {
    op_t        op;
    rec_t       word;
    bit         typed;
    status_t    status;
    logic [4:0] used;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_opcode;
  logic [7:0] in_key, in_year_in;
  logic [7:0] in_course_a_in, in_grade_a_in, in_course_b_in, in_grade_b_in;
  logic [7:0] in_course_c_in, in_grade_c_in;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_key_out, out_year_out;
  logic [7:0] out_course_a_out, out_grade_a_out, out_course_b_out, out_grade_b_out;
  logic [7:0] out_course_c_out, out_grade_c_out;
  logic [4:0] out_used_count;
  logic       out_is_full;
  logic       out_last;

  rec_t   shelf [DEPTH];
  int     kept;
  reply_t fresh [$];
  reply_t awaited [$];
  reply_t want;
  row_t   plan [$];
  int     errors;
  int     rcv_wait = 0;
  bit     calm;
  bit     grow;

  keyed_record_table_top #(.DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_key(in_key), .in_year_in(in_year_in),
    .in_course_a_in(in_course_a_in), .in_grade_a_in(in_grade_a_in),
    .in_course_b_in(in_course_b_in), .in_grade_b_in(in_grade_b_in),
    .in_course_c_in(in_course_c_in), .in_grade_c_in(in_grade_c_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_key_out(out_key_out), .out_year_out(out_year_out),
    .out_course_a_out(out_course_a_out), .out_grade_a_out(out_grade_a_out),
    .out_course_b_out(out_course_b_out), .out_grade_b_out(out_grade_b_out),
    .out_course_c_out(out_course_c_out), .out_grade_c_out(out_grade_c_out),
    .out_used_count(out_used_count), .out_is_full(out_is_full), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_reply(status_t s, rec_t d, bit lst);
    fresh.push_back('{status: s, data: d, used: 5'(kept), full: (kept == DEPTH), last: lst});
  endfunction

  // Table model: updates the shelf and leaves this word's replies in fresh.
  function automatic void apply_word(op_t op, rec_t w);
    int   hit;
    int   n;
    rec_t k;
    fresh.delete();
    hit = -1;
    for (int i = 0; i < kept; i++)
      if (hit < 0 && shelf[i].key == w.key) hit = i;
    if (op == OP_ADD) begin
      if (kept >= DEPTH) begin
        note_reply(ST_FULL, '0, 1'b1);
      end else begin
        shelf[kept] = w;
        kept++;
        note_reply(ST_OK, '0, 1'b1);
      end
    end else if (kept == 0) begin
      note_reply(ST_EMPTY, '0, 1'b1);
    end else if (op == OP_LIST) begin
      n = (kept > MAX_LIST) ? MAX_LIST : kept;
      for (int i = 0; i < n; i++) begin
        k = '0;
        k.key = shelf[i].key;
        note_reply(ST_OK, k, i == n - 1);
      end
    end else if (hit < 0) begin
      note_reply(ST_MISS, '0, 1'b1);
    end else if (op == OP_READ) begin
      note_reply(ST_OK, shelf[hit], 1'b1);
    end else begin
      for (int i = hit; i < kept - 1; i++) shelf[i] = shelf[i + 1];
      kept--;
      note_reply(ST_OK, '0, 1'b1);
    end
  endfunction

  function automatic row_t mk(op_t op, logic [7:0] key, logic [7:0] fill, bit typed,
                              status_t st, int used);
    row_t r;
    r.op = op;
    r.word = {8{fill}};
    r.word.key = key;
    r.typed = typed;
    r.status = st;
    r.used = 5'(used);
    return r;
  endfunction

  task automatic send_word(row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= r.op;
    in_key         <= r.word.key;
    in_year_in     <= r.word.year;
    in_course_a_in <= r.word.course_a;
    in_grade_a_in  <= r.word.grade_a;
    in_course_b_in <= r.word.course_b;
    in_grade_b_in  <= r.word.grade_b;
    in_course_c_in <= r.word.course_c;
    in_grade_c_in  <= r.word.grade_c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_word(r.op, r.word);
    if (r.typed)
      awaited.push_back('{status: r.status, data: '0, used: r.used,
                          full: (r.used == DEPTH), last: 1'b1});
    else
      foreach (fresh[i]) awaited.push_back(fresh[i]);
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("key_out", want.data.key, out_key_out);
        check_field("year_out", want.data.year, out_year_out);
        check_field("course_a_out", want.data.course_a, out_course_a_out);
        check_field("grade_a_out", want.data.grade_a, out_grade_a_out);
        check_field("course_b_out", want.data.course_b, out_course_b_out);
        check_field("grade_b_out", want.data.grade_b, out_grade_b_out);
        check_field("course_c_out", want.data.course_c, out_course_c_out);
        check_field("grade_c_out", want.data.grade_c, out_grade_c_out);
        check_field("used_count", 8'(want.used), 8'(out_used_count));
        check_field("is_full", 8'(want.full), 8'(out_is_full));
        check_field("last", 8'(want.last), 8'(out_last));
      end
      rcv_wait = calm ? 0 : $urandom_range(0, 19);
    end else if (rcv_wait > 0) begin
      rcv_wait--;
    end
    out_stall <= (rcv_wait > 0);
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    op_t  op;
    rec_t w;
    int   pick;
    errors = 0;
    kept = 0;
    calm = 1'b0;
    grow = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_ADD;
    in_key <= '0;
    in_year_in <= '0;
    in_course_a_in <= '0;
    in_grade_a_in <= '0;
    in_course_b_in <= '0;
    in_grade_b_in <= '0;
    in_course_c_in <= '0;
    in_grade_c_in <= '0;

    // empty table, duplicate keys, misses, compaction, full table, list of 16
    plan.push_back(mk(OP_READ, 8'h00, 8'h00, 1, ST_EMPTY, 0));
    plan.push_back(mk(OP_DEL,  8'hFF, 8'h00, 1, ST_EMPTY, 0));
    plan.push_back(mk(OP_LIST, 8'h00, 8'h00, 1, ST_EMPTY, 0));
    plan.push_back(mk(OP_ADD,  8'h00, 8'h00, 1, ST_OK, 1));
    plan.push_back(mk(OP_ADD,  8'hFF, 8'hFF, 1, ST_OK, 2));
    plan.push_back(mk(OP_ADD,  8'h00, 8'h5A, 1, ST_OK, 3));
    plan.push_back(mk(OP_READ, 8'hFF, 8'h00, 0, ST_OK, 0));
    plan.push_back(mk(OP_READ, 8'h07, 8'h00, 1, ST_MISS, 3));
    plan.push_back(mk(OP_DEL,  8'h07, 8'h00, 1, ST_MISS, 3));
    plan.push_back(mk(OP_DEL,  8'h00, 8'h00, 1, ST_OK, 2));
    plan.push_back(mk(OP_READ, 8'h00, 8'h00, 0, ST_OK, 0));
    for (int i = 0; i < DEPTH - 2; i++)
      plan.push_back(mk(OP_ADD, 8'(16 + i), 8'(i * 37 + 1), 1, ST_OK, 3 + i));
    plan.push_back(mk(OP_ADD,  8'h80, 8'hA5, 1, ST_FULL, DEPTH));
    plan.push_back(mk(OP_LIST, 8'h00, 8'h00, 0, ST_OK, 0));
    plan.push_back(mk(OP_READ, 8'(16 + DEPTH - 3), 8'h00, 0, ST_OK, 0));
    plan.push_back(mk(OP_DEL,  8'hFF, 8'h00, 1, ST_OK, DEPTH - 1));
    plan.push_back(mk(OP_ADD,  8'hC3, 8'h3C, 1, ST_OK, DEPTH));
    plan.push_back(mk(OP_DEL,  8'hC3, 8'h00, 1, ST_OK, DEPTH - 1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      send_word(plan[i]);
    end

    // alternate filling and draining phases; most lookups use a stored key
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      if (n % 50 == 0) grow = !grow;
      pick = $urandom_range(0, 99);
      if (pick < (grow ? 55 : 25)) op = OP_ADD;
      else if (pick < 70)          op = OP_READ;
      else if (pick < 90)          op = OP_DEL;
      else                         op = OP_LIST;
      w = rec_t'({$urandom(), $urandom()});
      if (op != OP_ADD && kept > 0 && $urandom_range(0, 9) < 7)
        w.key = shelf[$urandom_range(0, kept - 1)].key;
      else if ($urandom_range(0, 1) == 1)
        w.key = 8'($urandom_range(0, 15));
      send_word('{op: op, word: w, typed: 1'b0, status: ST_OK, used: 5'd0});
    end
    in_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited.size() != 0) begin
      $error("%0d expected result words never arrived", awaited.size());
      errors++;
    end
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== keyed_record_table_top.f =====
rtl/krt_pkg.sv
rtl/krt_mem.sv
rtl/keyed_record_table_top.sv
sim/tb.sv
